@@ rtl/core/pss_pkg.sv @@
// Shared types and constants for the pixel specular shading block.
// Used by pss_norm3, pixel_specular_shading and tb_top; depends on nothing else.
`default_nettype none

package pss_pkg;

    localparam int COMPONENT_WIDTH = 24;
    // The half vector l + e needs 17 signed bits, so the normalizer is never narrower.
    localparam int NORM_IN_W = (COMPONENT_WIDTH > 17) ? COMPONENT_WIDTH : 17;
    localparam int Q_W = 16;
    localparam int OUT_W = 16;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS = 16;
    localparam int NORM_LAT = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int Q14_ONE = 16384;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef logic signed [NORM_IN_W-1:0] norm_in_t;
    typedef logic signed [Q_W-1:0] q14_t;
    typedef norm_in_t [2:0] norm_vec_t;
    typedef q14_t [2:0] q14_vec_t;

    typedef struct packed {
        comp_t light_x;
        comp_t light_y;
        comp_t light_z;
        comp_t eye_x;
        comp_t eye_y;
        comp_t eye_z;
        comp_t normal_x;
        comp_t normal_y;
        comp_t normal_z;
    } shade_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] intensity;
        logic                    degenerate;
    } shade_out_t;

endpackage

`default_nettype wire

@@ rtl/core/pss_norm3.sv @@
// Pipelined three-component vector normalizer producing Q1.14 components.
// Depends on pss_pkg; one vector enters per cycle.
`default_nettype none

module pss_norm3 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  pss_pkg::norm_vec_t comp,
    output logic               out_valid,
    output logic               out_ok,
    output pss_pkg::q14_vec_t  unit
);
    import pss_pkg::*;

    localparam int MAG_W = NORM_IN_W;
    localparam int SQ_W = 2 * NORM_IN_W;
    localparam int WORD_W = 64;
    localparam int K_W = 5;
    localparam int ROOT_W = 31;
    localparam int DIVISOR_W = ROOT_W + 1;
    localparam int DIV_W = 48;
    localparam int QUO_W = DIV_STEPS;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        mag_t [2:0] mag;
        logic [2:0] neg;
    } front_t;

    typedef struct packed {
        mag_t [2:0]     mag;
        logic [2:0]     neg;
        logic [K_W-1:0] k;
        logic           dv;
        logic           zero;
    } root_side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } div_side_t;

    logic [NORM_LAT-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NORM_LAT-2:0], in_valid};
        end
    end

    // Magnitudes and signs.
    front_t f1_reg, f1_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f1_next.neg[i] = comp[i][NORM_IN_W-1];
            f1_next.mag[i] = comp[i][NORM_IN_W-1] ? MAG_W'(-$signed(comp[i]))
                                                  : MAG_W'($signed(comp[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg <= f1_next;
    end

    // Squares.
    logic [SQ_W-1:0] sq_reg [3];
    front_t          f2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= SQ_W'(f1_reg.mag[i]) * SQ_W'(f1_reg.mag[i]);
        end
        f2_reg <= f1_reg;
    end

    // Sum of squares, exact.
    logic [WORD_W-1:0] sum_reg;
    front_t            f3_reg;

    always_ff @(posedge clk)
    begin
        sum_reg <= WORD_W'(sq_reg[0]) + WORD_W'(sq_reg[1]) + WORD_W'(sq_reg[2]);
        f3_reg  <= f2_reg;
    end

    // Scale by the largest even power of two that keeps the word below 2^62
    // in halving steps over two stages; shift right by two from 2^62 up.
    logic [WORD_W-1:0] w4_next, w4_reg;
    root_side_t        s4_next, s4_reg;

    always_comb
    begin
        w4_next      = sum_reg;
        s4_next.mag  = f3_reg.mag;
        s4_next.neg  = f3_reg.neg;
        s4_next.zero = (sum_reg == '0);
        s4_next.dv   = (sum_reg[63:62] != 2'b00);
        s4_next.k    = '0;
        if (s4_next.dv)
        begin
            w4_next = sum_reg >> 2;
        end
        else
        begin
            if (w4_next[63:30] == '0)
            begin
                w4_next   = w4_next << 32;
                s4_next.k = s4_next.k + K_W'(16);
            end
            if (w4_next[63:46] == '0)
            begin
                w4_next   = w4_next << 16;
                s4_next.k = s4_next.k + K_W'(8);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w4_reg <= w4_next;
        s4_reg <= s4_next;
    end

    logic [WORD_W-1:0] w5_next;
    root_side_t        s5_next;

    always_comb
    begin
        w5_next = w4_reg;
        s5_next = s4_reg;
        if (!s4_reg.dv)
        begin
            if (w5_next[63:54] == '0)
            begin
                w5_next   = w5_next << 8;
                s5_next.k = s5_next.k + K_W'(4);
            end
            if (w5_next[63:58] == '0)
            begin
                w5_next   = w5_next << 4;
                s5_next.k = s5_next.k + K_W'(2);
            end
            if (w5_next[63:60] == '0)
            begin
                w5_next   = w5_next << 2;
                s5_next.k = s5_next.k + K_W'(1);
            end
        end
    end

    // Integer square root, one result bit per stage.
    logic [WORD_W-1:0] sx_reg [SQRT_STEPS+1];
    logic [WORD_W-1:0] sr_reg [SQRT_STEPS+1];
    root_side_t        rs_reg [SQRT_STEPS+1];

    always_ff @(posedge clk)
    begin
        sx_reg[0] <= w5_next;
        sr_reg[0] <= '0;
        rs_reg[0] <= s5_next;
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_root
        localparam logic [WORD_W-1:0] ROOT_BIT = WORD_W'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [WORD_W-1:0] trial;
        logic [WORD_W-1:0] x_next;
        logic [WORD_W-1:0] r_next;

        always_comb
        begin
            trial = sr_reg[j] + ROOT_BIT;
            if (sx_reg[j] >= trial)
            begin
                x_next = sx_reg[j] - trial;
                r_next = (sr_reg[j] >> 1) + ROOT_BIT;
            end
            else
            begin
                x_next = sx_reg[j];
                r_next = sr_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            sx_reg[j+1] <= x_next;
            sr_reg[j+1] <= r_next;
            rs_reg[j+1] <= rs_reg[j];
        end
    end

    // Rounded quotient |c| * 2^sh / m is floor((2*num + m) / (2*m)).
    logic [ROOT_W-1:0]          root;
    logic [2:0][DIV_W-1:0]      num_w;
    logic [2:0][DIV_W-1:0]      d0_next;
    root_side_t                 rs_last;

    logic [2:0][DIV_W-1:0]      dr_reg [DIV_STEPS+1];
    logic [2:0][QUO_W-1:0]      q_reg  [DIV_STEPS+1];
    logic [DIVISOR_W-1:0]       b_reg  [DIV_STEPS+1];
    div_side_t                  ds_reg [DIV_STEPS+1];

    always_comb
    begin
        root    = sr_reg[SQRT_STEPS][ROOT_W-1:0];
        rs_last = rs_reg[SQRT_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            if (rs_last.dv)
            begin
                num_w[i] = DIV_W'(rs_last.mag[i]) << 13;
            end
            else
            begin
                num_w[i] = (DIV_W'(rs_last.mag[i]) << rs_last.k) << 14;
            end
            d0_next[i] = (num_w[i] << 1) + DIV_W'(root);
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg[0]      <= d0_next;
        q_reg[0]       <= '0;
        b_reg[0]       <= {root, 1'b0};
        ds_reg[0].neg  <= rs_last.neg;
        ds_reg[0].zero <= rs_last.zero;
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [DIV_W-1:0]      trial;
        logic [2:0][DIV_W-1:0] r_next;
        logic [2:0][QUO_W-1:0] q_next;

        always_comb
        begin
            trial = DIV_W'(b_reg[j]) << SH;
            for (int i = 0; i < 3; i++)
            begin
                if (dr_reg[j][i] >= trial)
                begin
                    r_next[i] = dr_reg[j][i] - trial;
                    q_next[i] = q_reg[j][i] | (QUO_W'(1) << SH);
                end
                else
                begin
                    r_next[i] = dr_reg[j][i];
                    q_next[i] = q_reg[j][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dr_reg[j+1] <= r_next;
            q_reg[j+1]  <= q_next;
            b_reg[j+1]  <= b_reg[j];
            ds_reg[j+1] <= ds_reg[j];
        end
    end

    // Clamp to one, restore the sign, force zero for a zero-length vector.
    q14_vec_t          unit_next, unit_reg;
    logic              ok_reg;
    logic [QUO_W-1:0]  qmag;
    div_side_t         ds_last;

    always_comb
    begin
        ds_last = ds_reg[DIV_STEPS];
        qmag    = '0;
        for (int i = 0; i < 3; i++)
        begin
            qmag = q_reg[DIV_STEPS][i];
            if (qmag > QUO_W'(Q14_ONE))
            begin
                qmag = QUO_W'(Q14_ONE);
            end
            if (ds_last.zero)
            begin
                unit_next[i] = '0;
            end
            else if (ds_last.neg[i])
            begin
                unit_next[i] = -Q_W'(qmag);
            end
            else
            begin
                unit_next[i] = Q_W'(qmag);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        ok_reg   <= !ds_last.zero;
    end

    assign out_valid = valid_reg[NORM_LAT-1];
    assign out_ok    = ok_reg;
    assign unit      = unit_reg;

endmodule

`default_nettype wire

@@ rtl/core/pixel_specular_shading.sv @@
// Top level of the per-pixel specular shading pipeline.
// Depends on pss_pkg and pss_norm3 (three input normalizers, one half-vector normalizer).
`default_nettype none

// Usage
// A pixel word (light, eye and normal vectors, signed Q15.8 components) is
// taken on every rising edge at which start is high; busy is always low, so
// one word can be offered in every cycle with no gaps.
// Each word produces exactly one result word: done is high for one cycle and
// shade carries the intensity (signed Q2.13, saturated) and the degenerate flag.
// Results come out in input order. The path from the edge that took the word
// is two normalizer passes in series, each a 31-stage square root and a
// 16-stage divider, plus the shading arithmetic.
// Throughput is one word per cycle at any fill level.
// Reset clears every valid bit, so no done pulse follows reset until a word
// is accepted; words in flight at reset are dropped.
// The receiver has no way to stall: a result exists on shade only in the
// cycle in which done is high.
module pixel_specular_shading (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pss_pkg::shade_in_t  pixel,
    output logic                done,
    output pss_pkg::shade_out_t shade
);
    import pss_pkg::*;

    localparam int PROD_W = 2 * Q_W;
    localparam int SUM_W = PROD_W + 2;
    localparam int HN_W = 15;
    localparam int MUL_W = 2 * HN_W + 1;
    localparam int FX_W = 20;
    localparam int RECIP_W = 19;
    localparam int RP_W = FX_W + RECIP_W;
    localparam int FAC_W = 16;
    localparam int PR_W = Q_W + FAC_W + 1;
    localparam int TAIL = 8;
    localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(419431);
    localparam int HALF14 = 8192;
    localparam int HALF15 = 16384;
    localparam int BASE_080 = 65536;
    localparam int SPEC_MUL = 7;
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN_MAG = 32768;

    typedef struct packed {
        q14_vec_t n;
        logic     ok;
        q14_t     nl;
    } hside_t;

    // Dot product rounding: nearest, half away from zero, clamped to one.
    function automatic q14_t dot_round(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] q;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        q   = (mag + SUM_W'(HALF14)) >> 14;
        if (q > SUM_W'(Q14_ONE))
        begin
            q = SUM_W'(Q14_ONE);
        end
        return s[SUM_W-1] ? -Q_W'(q) : Q_W'(q);
    endfunction

    assign busy = 1'b0;

    // Input normalizers.
    norm_vec_t lc, ec, nc;
    q14_vec_t  lu, eu, nu, hu;
    logic      l_valid, h_valid;
    logic      l_ok, e_ok, n_ok;

    assign lc[0] = NORM_IN_W'(pixel.light_x);
    assign lc[1] = NORM_IN_W'(pixel.light_y);
    assign lc[2] = NORM_IN_W'(pixel.light_z);
    assign ec[0] = NORM_IN_W'(pixel.eye_x);
    assign ec[1] = NORM_IN_W'(pixel.eye_y);
    assign ec[2] = NORM_IN_W'(pixel.eye_z);
    assign nc[0] = NORM_IN_W'(pixel.normal_x);
    assign nc[1] = NORM_IN_W'(pixel.normal_y);
    assign nc[2] = NORM_IN_W'(pixel.normal_z);

    pss_norm3 u_norm_light (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .comp      (lc),
        .out_valid (l_valid),
        .out_ok    (l_ok),
        .unit      (lu)
    );

    pss_norm3 u_norm_eye (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .comp      (ec),
        .out_valid (),
        .out_ok    (e_ok),
        .unit      (eu)
    );

    pss_norm3 u_norm_normal (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .comp      (nc),
        .out_valid (),
        .out_ok    (n_ok),
        .unit      (nu)
    );

    // Half-vector sum and the n.l products.
    logic                      t1_valid_reg;
    norm_vec_t                 hs_next, hs_reg;
    logic signed [PROD_W-1:0]  nlp_next [3];
    logic signed [PROD_W-1:0]  nlp_reg [3];
    q14_vec_t                  n1_reg;
    logic                      ok1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hs_next[i]  = NORM_IN_W'($signed(lu[i])) + NORM_IN_W'($signed(eu[i]));
            nlp_next[i] = PROD_W'($signed(lu[i])) * PROD_W'($signed(nu[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= l_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hs_reg  <= hs_next;
        nlp_reg <= nlp_next;
        n1_reg  <= nu;
        ok1_reg <= l_ok & e_ok & n_ok;
    end

    pss_norm3 u_norm_half (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t1_valid_reg),
        .comp      (hs_reg),
        .out_valid (h_valid),
        .out_ok    (),
        .unit      (hu)
    );

    // The normal, n.l and the flag wait alongside the half-vector normalizer.
    hside_t side_reg [NORM_LAT];
    hside_t side_next;

    always_comb
    begin
        side_next.n  = n1_reg;
        side_next.ok = ok1_reg;
        side_next.nl = dot_round(SUM_W'(nlp_reg[0]) + SUM_W'(nlp_reg[1])
                                 + SUM_W'(nlp_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < NORM_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Shading tail.
    logic [TAIL-1:0]           tv_reg;
    q14_t                      nl_pipe_reg [TAIL];
    logic                      ok_pipe_reg [TAIL];
    logic signed [PROD_W-1:0]  hnp_next [3];
    logic signed [PROD_W-1:0]  hnp_reg [3];
    q14_t                      hn_signed;
    logic [HN_W-1:0]           hn_next, hn4_reg, hn5_reg, hn6_reg;
    logic [HN_W-1:0]           p2_reg, p4_reg, p5_reg;
    logic [FX_W-1:0]           fx_reg;
    logic [FAC_W-1:0]          factor_reg;
    logic signed [PR_W-1:0]    prod_reg;
    hside_t                    side_last;

    always_comb
    begin
        side_last = side_reg[NORM_LAT-1];
        for (int i = 0; i < 3; i++)
        begin
            hnp_next[i] = PROD_W'($signed(hu[i])) * PROD_W'($signed(side_last.n[i]));
        end
        hn_signed = dot_round(SUM_W'(hnp_reg[0]) + SUM_W'(hnp_reg[1])
                              + SUM_W'(hnp_reg[2]));
        hn_next   = hn_signed[Q_W-1] ? '0 : hn_signed[HN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else
        begin
            tv_reg <= {tv_reg[TAIL-2:0], h_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        hnp_reg        <= hnp_next;
        nl_pipe_reg[0] <= side_last.nl;
        ok_pipe_reg[0] <= side_last.ok;
        for (int k = 1; k < TAIL; k++)
        begin
            nl_pipe_reg[k] <= nl_pipe_reg[k-1];
            ok_pipe_reg[k] <= ok_pipe_reg[k-1];
        end

        hn4_reg <= hn_next;

        p2_reg  <= HN_W'((MUL_W'(hn4_reg) * MUL_W'(hn4_reg) + MUL_W'(HALF14)) >> 14);
        hn5_reg <= hn4_reg;

        p4_reg  <= HN_W'((MUL_W'(p2_reg) * MUL_W'(p2_reg) + MUL_W'(HALF14)) >> 14);
        hn6_reg <= hn5_reg;

        p5_reg  <= HN_W'((MUL_W'(p4_reg) * MUL_W'(hn6_reg) + MUL_W'(HALF14)) >> 14);

        // Ten times (0.8 + 1.4 * p5) in Q.14 units, plus five for rounding after /10.
        fx_reg  <= ((FX_W'(p5_reg) * FX_W'(SPEC_MUL) + FX_W'(BASE_080)) << 1) + FX_W'(5);

        // Divide by ten through the reciprocal; exact for every value fx can take.
        factor_reg <= FAC_W'((RP_W'(fx_reg) * RP_W'(RECIP_TEN)) >> 22);

        prod_reg <= PR_W'($signed(nl_pipe_reg[6])) * PR_W'($signed({1'b0, factor_reg}));
    end

    // Round to Q2.13, saturate, apply the degenerate case.
    logic               done_reg;
    shade_out_t         shade_reg, shade_next;
    logic [PR_W-1:0]    pmag;
    logic [PR_W-1:0]    pq;

    always_comb
    begin
        pmag = prod_reg[PR_W-1] ? PR_W'(-prod_reg) : PR_W'(prod_reg);
        pq   = (pmag + PR_W'(HALF15)) >> 15;
        shade_next.degenerate = 1'b0;
        if (!prod_reg[PR_W-1])
        begin
            shade_next.intensity = (pq > PR_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(pq);
        end
        else
        begin
            shade_next.intensity = (pq > PR_W'(OUT_MIN_MAG)) ? -OUT_W'(OUT_MIN_MAG)
                                                             : -OUT_W'(pq);
        end
        if (!ok_pipe_reg[TAIL-1])
        begin
            shade_next.intensity  = '0;
            shade_next.degenerate = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tv_reg[TAIL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        shade_reg <= shade_next;
    end

    assign done  = done_reg;
    assign shade = shade_reg;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for pixel_specular_shading: a directed table, then random pixel words.
// Results are predicted by an in-bench fixed-point shading model; depends on pss_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import pss_pkg::*;

    localparam int LATENCY = 118;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    shade_in_t pixel;
    logic done;
    shade_out_t shade;

    shade_out_t shade_expected_q[$];
    int mismatches;
    int results_seen;
    int degenerate_seen;
    int words_sent;
    int sender_idle_pct;

    typedef struct {
        shade_in_t  word;
        logic       has_golden;
        shade_out_t golden;
    } pixel_row_t;

    pixel_row_t directed_rows[$];

    pixel_specular_shading DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .done(done),
        .shade(shade)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_shift(longint x, int sh);
        longint unsigned a;
        longint unsigned q;
        a = (x < 0) ? -x : x;
        q = (a + (64'd1 << (sh - 1))) >> sh;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Scales a vector to unit length in Q1.14; returns 0 for a zero vector.
    function automatic bit unit_vector(input longint c[3], output longint u[3]);
        longint unsigned a[3];
        longint unsigned s;
        longint unsigned m;
        longint unsigned q;
        longint unsigned num;
        int sh;
        int k;
        s = 0;
        k = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = (c[i] < 0) ? -c[i] : c[i];
            s += a[i] * a[i];
            u[i] = 0;
        end
        if (s == 0)
            return 0;
        if (s >= (64'd1 << 62))
        begin
            s >>= 2;
            sh = 13;
        end
        else
        begin
            while (k < 30 && s < ((64'd1 << 62) >> (2 * k + 2)))
                k++;
            s <<= 2 * k;
            sh = 14 + k;
        end
        m = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            num = a[i] << sh;
            q = (2 * num + m) / (2 * m);
            if (q > Q14_ONE)
                q = Q14_ONE;
            u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic longint dot_q14(longint a[3], longint b[3]);
        longint r;
        r = round_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 14);
        if (r > Q14_ONE)
            r = Q14_ONE;
        if (r < -Q14_ONE)
            r = -Q14_ONE;
        return r;
    endfunction

    function automatic shade_out_t shade_pixel(shade_in_t w);
        longint lv[3];
        longint ev[3];
        longint nv[3];
        longint l[3];
        longint e[3];
        longint n[3];
        longint hs[3];
        longint h[3];
        longint nl;
        longint hn;
        longint p2;
        longint p4;
        longint p5;
        longint factor;
        longint inten;
        bit ok;
        shade_out_t r;
        lv = '{longint'(w.light_x), longint'(w.light_y), longint'(w.light_z)};
        ev = '{longint'(w.eye_x), longint'(w.eye_y), longint'(w.eye_z)};
        nv = '{longint'(w.normal_x), longint'(w.normal_y), longint'(w.normal_z)};
        ok = unit_vector(lv, l);
        ok = unit_vector(ev, e) & ok;
        ok = unit_vector(nv, n) & ok;
        if (!ok)
        begin
            r.intensity = '0;
            r.degenerate = 1'b1;
            return r;
        end
        nl = dot_q14(n, l);
        for (int i = 0; i < 3; i++)
            hs[i] = l[i] + e[i];
        void'(unit_vector(hs, h));
        hn = dot_q14(h, n);
        if (hn < 0)
            hn = 0;
        p2 = (hn * hn + 8192) >>> 14;
        p4 = (p2 * p2 + 8192) >>> 14;
        p5 = (p4 * hn + 8192) >>> 14;
        factor = (2 * (65536 + 7 * p5) + 5) / 10;
        inten = round_shift(nl * factor, 15);
        if (inten > 32767)
            inten = 32767;
        if (inten < -32768)
            inten = -32768;
        r.intensity = inten[15:0];
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic comp_t random_component();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        // Mix full-range, small and edge values; the shift-right scaling branch is never hit.
        case (sel)
            0: return comp_t'($urandom);
            1, 2: return comp_t'($signed($urandom_range(0, 1023)) - 512);
            3: return comp_t'(24'h800000);
            4: return comp_t'(24'h7fffff);
            5: return '0;
            default: return comp_t'($signed($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    function automatic shade_in_t random_pixel();
        shade_in_t w;
        w.light_x = random_component();
        w.light_y = random_component();
        w.light_z = random_component();
        w.eye_x = random_component();
        w.eye_y = random_component();
        w.eye_z = random_component();
        w.normal_x = random_component();
        w.normal_y = random_component();
        w.normal_z = random_component();
        // Most words are nonzero vectors; only a few become degenerate.
        if ($urandom_range(0, 19) != 0)
        begin
            if (w.light_x == 0 && w.light_y == 0 && w.light_z == 0)
                w.light_z = 24'sd256;
            if (w.eye_x == 0 && w.eye_y == 0 && w.eye_z == 0)
                w.eye_z = 24'sd256;
            if (w.normal_x == 0 && w.normal_y == 0 && w.normal_z == 0)
                w.normal_z = 24'sd256;
        end
        // Sometimes make the eye exactly opposite the light.
        if ($urandom_range(0, 24) == 0)
        begin
            w.eye_x = -w.light_x;
            w.eye_y = -w.light_y;
            w.eye_z = -w.light_z;
        end
        return w;
    endfunction

    function automatic shade_in_t make_pixel(int lx, int ly, int lz, int ex, int ey, int ez,
                                             int nx, int ny, int nz);
        shade_in_t w;
        w.light_x = comp_t'(lx);
        w.light_y = comp_t'(ly);
        w.light_z = comp_t'(lz);
        w.eye_x = comp_t'(ex);
        w.eye_y = comp_t'(ey);
        w.eye_z = comp_t'(ez);
        w.normal_x = comp_t'(nx);
        w.normal_y = comp_t'(ny);
        w.normal_z = comp_t'(nz);
        return w;
    endfunction

    function automatic void add_row(shade_in_t w, logic has_golden, int inten, logic degen);
        pixel_row_t row;
        row.word = w;
        row.has_golden = has_golden;
        row.golden.intensity = 16'(inten);
        row.golden.degenerate = degen;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic send_word(shade_in_t w);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shade_expected_q.insert(shade_expected_q.size(), shade_pixel(w));
        words_sent++;
    endtask

    // Results are sampled on the edge that ends the strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            shade_out_t want;
            results_seen++;
            if (shade_expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: intensity %0d degenerate %0b",
                             shade.intensity, shade.degenerate);
            end
            else
            begin
                want = shade_expected_q.pop_front();
                if (want.degenerate)
                    degenerate_seen++;
                if (shade.intensity !== want.intensity || shade.degenerate !== want.degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: intensity %0d/%0d degenerate %0b/%0b (exp/act)",
                                 want.intensity, shade.intensity,
                                 want.degenerate, shade.degenerate);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("FAIL pixel_specular_shading");
        $finish;
    end

    initial
    begin
        int drain;
        mismatches = 0;
        results_seen = 0;
        degenerate_seen = 0;
        words_sent = 0;
        sender_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-length vectors flag the word and force intensity to zero.
        add_row(make_pixel(0, 0, 0, 0, 0, 256, 0, 0, 256), 1, 0, 1);
        add_row(make_pixel(0, 0, 256, 0, 0, 0, 0, 0, 256), 1, 0, 1);
        add_row(make_pixel(0, 0, 256, 0, 0, 256, 0, 0, 0), 1, 0, 1);
        add_row(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1);
        // Everything aligned: n.l = 1, h.n = 1, so the factor 2.2 passes straight through.
        add_row(make_pixel(0, 0, 256, 0, 0, 256, 0, 0, 256), 1, 18023, 0);
        // Light opposite the normal: the unclamped diffuse goes negative.
        add_row(make_pixel(0, 0, -256, 0, 0, -256, 0, 0, 256), 1, -6554, 0);
        // Light perpendicular to the normal gives zero.
        add_row(make_pixel(256, 0, 0, 256, 0, 0, 0, 0, 256), 1, 0, 0);
        // Light and eye opposite: the half vector collapses, no specular.
        add_row(make_pixel(0, 0, 256, 0, 0, -256, 0, 0, 256), 1, 6554, 0);
        add_row(make_pixel(300, -700, 100, -300, 700, -100, 1, 2, 3), 0, 0, 0);
        // Component extremes and tiny components for the normalizer's scaling search.
        add_row(make_pixel(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                           -8388608, 8388607, -8388608), 0, 0, 0);
        add_row(make_pixel(8388607, 0, 0, 1, 0, 0, -8388608, 0, 0), 1, -6554, 0);
        add_row(make_pixel(1, 1, 1, -1, -1, 1, 1, 0, 1), 0, 0, 0);
        add_row(make_pixel(1, 0, 0, 0, 1, 0, 0, 0, 1), 0, 0, 0);
        add_row(make_pixel(500, 300, 900, -200, 100, 800, 10, 20, 300), 0, 0, 0);
        add_row(make_pixel(-8388608, 1, 0, 0, -8388608, 1, 1, 0, -8388608), 0, 0, 0);
        add_row(make_pixel(4000, -4000, 256, 7, -9, 13, -3, 5, 8), 0, 0, 0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_golden &&
                directed_rows[i].golden !== shade_pixel(directed_rows[i].word))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Directed row %0d disagrees with the shading model", i);
            end
            send_word(directed_rows[i].word);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 77;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 31;
            endcase
            for (int i = 0; i < 310; i++)
                send_word(random_pixel());
        end
        start <= 1'b0;

        while (shade_expected_q.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < LATENCY + 20)
        begin
            @(posedge clk);
            drain++;
        end

        $display("Sent %0d pixel words, checked %0d results (%0d degenerate), %0d mismatches.",
                 words_sent, results_seen, degenerate_seen, mismatches);
        if (mismatches == 0)
            $display("PASS pixel_specular_shading");
        else
            $display("FAIL pixel_specular_shading");
        $finish;
    end

endmodule

@@ pixel_specular_shading.f @@
rtl/core/pss_pkg.sv
rtl/core/pss_norm3.sv
rtl/core/pixel_specular_shading.sv
dv/tb_top.sv
